>>> rtl/mlp_inference_relu_core_macros.svh
// Assertion macros shared by the MLP inference core.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef MLP_INFERENCE_RELU_CORE_MACROS_SVH
`define MLP_INFERENCE_RELU_CORE_MACROS_SVH

// Check an expression on every clock edge out of reset.
`define MLPIR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define MLPIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mlpir_pkg.sv
// Shared types, constants and arithmetic helpers of the MLP inference core.
// No dependencies.
`timescale 1ns / 1ps

package mlpir_pkg;

  localparam int MAX_NEURONS = 64;
  localparam int MAX_HIDDEN  = 4;
  localparam int PARAM_DEPTH = 4096;
  localparam int DATA_WIDTH  = 16;
  localparam int FIFO_DEPTH  = 4;

  // input item kinds as seen on in_tuser
  localparam logic [1:0] MODE_PARAM = 2'd0;
  localparam logic [1:0] MODE_FEAT  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_INPUT_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HIDDEN_LAYERS = 3'd1;
  localparam logic [2:0] REG_HIDDEN_A      = 3'd2;
  localparam logic [2:0] REG_HIDDEN_B      = 3'd3;
  localparam logic [2:0] REG_HIDDEN_C      = 3'd4;
  localparam logic [2:0] REG_HIDDEN_D      = 3'd5;
  localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd6;
  localparam logic [2:0] REG_PARAM_COUNT   = 3'd7;

  typedef enum logic [1:0] {
    CMD_PARAM = 2'd0,
    CMD_FEAT  = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] index;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  input_width;
    logic [2:0]  hidden_layers;
    logic [6:0]  hidden_a;
    logic [6:0]  hidden_b;
    logic [6:0]  hidden_c;
    logic [6:0]  hidden_d;
    logic [6:0]  output_width;
    logic [12:0] param_count;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // sigmoid(k/2) * 65536, k = 0..16
  localparam logic [15:0] SIG_TAB [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  function automatic logic [6:0] clamp_n(input logic [6:0] v);
    return (v > 7'(MAX_NEURONS)) ? 7'(MAX_NEURONS) : v;
  endfunction

  // Floor-shift the Q16.16 sum to Q8.8, saturate, optionally ReLU.
  function automatic logic [15:0] finish_sum(input logic [39:0] acc, input logic relu);
    logic signed [31:0] q;
    logic [15:0] r;
    q = $signed(acc[39:8]);
    if (q > 32'sd32767) r = 16'h7fff;
    else if (q < -32'sd32768) r = 16'h8000;
    else r = q[15:0];
    if (relu && r[15]) r = '0;
    return r;
  endfunction

  function automatic logic [15:0] sigmoid_q16(input logic [15:0] y);
    logic [16:0] a;
    logic [3:0]  seg;
    logic [6:0]  frac;
    logic [15:0] lo;
    logic [15:0] diff;
    logic [22:0] m;
    logic [15:0] p;
    a    = y[15] ? (17'd0 - {y[15], y}) : {1'b0, y};
    seg  = a[10:7];
    frac = a[6:0];
    lo   = SIG_TAB[seg];
    diff = SIG_TAB[5'(seg) + 5'd1] - lo;
    m    = 23'(diff) * 23'(frac);
    p    = (a >= 17'd2048) ? SIG_TAB[16] : lo + 16'(m >> 7);
    return y[15] ? 16'(17'h10000 - {1'b0, p}) : p;
  endfunction

endpackage

>>> rtl/mlpir_front.sv
// Front end: accepts input items, drops those that do nothing, classifies the rest.
// Depends on mlpir_pkg.
`timescale 1ns / 1ps

module mlpir_front import mlpir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] index, [27:12] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  fifo_stat_t  q_stat,
  output logic        q_push,
  output cmd_t        q_data
);

  logic keep;
  logic seen_r;

  always_comb begin
    keep          = 1'b0;
    q_data.kind   = CMD_PARAM;
    q_data.index  = in_tdata[11:0];
    q_data.value  = in_tdata[27:12];
    case (in_tuser)
      MODE_PARAM: begin
        keep        = 1'b1;
        q_data.kind = CMD_PARAM;
      end
      MODE_FEAT: begin
        // feature indexes beyond the buffer are dropped
        keep        = (in_tdata[11:6] == 6'd0);
        q_data.kind = CMD_FEAT;
      end
      MODE_RUN: begin
        keep        = 1'b1;
        q_data.kind = CMD_RUN;
      end
      default: keep = 1'b0;
    endcase
  end

  // hold off input for the first cycle out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) seen_r <= 1'b0;
    else        seen_r <= 1'b1;
  end

  assign in_tready = seen_r && !q_stat.full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

>>> rtl/mlpir_fifo.sv
// Short command queue between the front end and the compute engine.
// Depends on mlpir_pkg.
`timescale 1ns / 1ps

module mlpir_fifo import mlpir_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_data,
  input  logic       pop,
  output cmd_t       pop_data,
  output fifo_stat_t stat
);

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [PW:0]   cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign pop_data   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/mlpir_div.sv
// Restoring divider, one quotient bit per cycle, for the inferred output count.
// Depends on mlpir_pkg.
`timescale 1ns / 1ps

module mlpir_div import mlpir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [12:0] quot,
  output logic [6:0]  rmd
);

  logic [12:0] quo_r;
  logic [7:0]  rem_r;
  logic [6:0]  dvs_r;
  logic [3:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [7:0]  trial;
  logic        qbit;

  always_comb begin
    trial = {rem_r[6:0], quo_r[12]};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[11:0], qbit};
      rem_r <= qbit ? trial - {1'b0, dvs_r} : trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 4'd13;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 4'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rmd  = rem_r[6:0];

endmodule

>>> rtl/mlpir_engine.sv
// Back end: parameter, feature and activation memories, the MAC pipeline,
// the layer sequencer and the result register. Depends on mlpir_pkg, mlpir_div.
`timescale 1ns / 1ps

module mlpir_engine import mlpir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  fifo_stat_t  q_stat,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [5:0]  o_index,
  output logic [15:0] o_value,
  output logic [15:0] o_prob,
  output logic        o_last
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_NEUR  = 9'b000000010,
    S_ISSUE = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_FIN   = 9'b000010000,
    S_SIG   = 9'b000100000,
    S_EMIT  = 9'b001000000,
    S_LAYER = 9'b010000000,
    S_OSET  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] param_mem [PARAM_DEPTH];
  logic [15:0] feat_mem  [MAX_NEURONS];
  logic [15:0] act_mem   [2*MAX_NEURONS];
  logic [63:0] feat_vld_r;
  logic [6:0]  feat_cnt_r;

  logic [12:0] cnt_r, ptr_r;
  logic [2:0]  layer_r, nh_r;
  logic [6:0]  n_in_r, n_out_r, neur_r, elem_r;
  logic        src_feat_r, src_bank_r, dst_bank_r, out_layer_r;
  logic [39:0] acc_r;
  logic [15:0] y_r, prob_r;

  logic        s1_v_r, s1_bias_r, s1_pz_r, s1_feat_r;
  logic [15:0] p_rd_r, f_rd_r, a_rd_r;
  logic        f_vld_rd_r;
  logic        s2_v_r;
  logic signed [31:0] prod_r;

  logic        out_valid_r, out_last_r;
  logic [5:0]  out_idx_r;
  logic [15:0] out_val_r, out_prob_r;

  logic        div_start, div_done, div_sent_r;
  logic [12:0] div_q, rem_w;
  logic [6:0]  div_r;

  logic        do_pop, emit_go, bias_elem;
  logic [2:0]  nh_w;
  logic [15:0] fin_w;
  logic signed [15:0] w_s, x_s;
  logic [6:0]  hs [MAX_HIDDEN];

  assign hs[0] = cfg.hidden_a;
  assign hs[1] = cfg.hidden_b;
  assign hs[2] = cfg.hidden_c;
  assign hs[3] = cfg.hidden_d;

  assign do_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign q_pop     = do_pop;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign bias_elem = (elem_r == n_in_r);
  assign nh_w      = (cfg.hidden_layers > 3'(MAX_HIDDEN)) ? 3'(MAX_HIDDEN) : cfg.hidden_layers;
  assign fin_w     = finish_sum(acc_r, !out_layer_r);
  assign rem_w     = (ptr_r < cnt_r) ? cnt_r - ptr_r : 13'd0;
  // pulse start on the first cycle in S_OSET only
  assign div_start = (state_r == S_OSET) && (cfg.output_width == 7'd0) && !div_sent_r;

  mlpir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_w),
    .divisor  (n_in_r + 7'd1),
    .done     (div_done),
    .quot     (div_q),
    .rmd      (div_r)
  );

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (do_pop && q_data.kind == CMD_PARAM) param_mem[q_data.index] <= q_data.value;
    p_rd_r <= param_mem[ptr_r[11:0]];
  end

  always_ff @(posedge clk) begin
    if (do_pop && q_data.kind == CMD_FEAT) feat_mem[q_data.index[5:0]] <= q_data.value;
    f_rd_r <= feat_mem[elem_r[5:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && !out_layer_r) act_mem[{dst_bank_r, neur_r[5:0]}] <= fin_w;
    a_rd_r <= act_mem[{src_bank_r, elem_r[5:0]}];
  end

  // MAC pipeline payload
  always_comb begin
    w_s = s1_pz_r ? 16'sd0 : $signed(p_rd_r);
    x_s = s1_feat_r ? (f_vld_rd_r ? $signed(f_rd_r) : 16'sd0) : $signed(a_rd_r);
  end

  always_ff @(posedge clk) begin
    s1_bias_r  <= bias_elem;
    s1_pz_r    <= (ptr_r >= cnt_r);
    s1_feat_r  <= src_feat_r;
    f_vld_rd_r <= feat_vld_r[elem_r[5:0]];
    prod_r     <= s1_bias_r ? (32'(w_s) <<< 8) : (w_s * x_s);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (do_pop && q_data.kind == CMD_RUN) state_nxt = (nh_w != 3'd0) ? S_NEUR : S_OSET;
      S_NEUR:  begin
        if (neur_r == n_out_r) state_nxt = out_layer_r ? S_IDLE : S_LAYER;
        else                   state_nxt = S_ISSUE;
      end
      S_ISSUE: if (bias_elem) state_nxt = S_DRAIN;
      S_DRAIN: if (!s1_v_r && !s2_v_r) state_nxt = S_FIN;
      S_FIN: begin
        if (!out_layer_r)        state_nxt = S_NEUR;
        else if (neur_r == 7'd0) state_nxt = S_SIG;
        else                     state_nxt = S_EMIT;
      end
      S_SIG:   state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = S_NEUR;
      S_LAYER: state_nxt = (layer_r + 3'd1 < nh_r) ? S_NEUR : S_OSET;
      S_OSET:  if (cfg.output_width != 7'd0 || div_done) state_nxt = S_NEUR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      feat_vld_r  <= '0;
      feat_cnt_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_sent_r  <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      layer_r     <= '0;
      nh_r        <= '0;
      n_in_r      <= '0;
      n_out_r     <= '0;
      neur_r      <= '0;
      elem_r      <= '0;
      src_feat_r  <= 1'b1;
      src_bank_r  <= 1'b0;
      dst_bank_r  <= 1'b0;
      out_layer_r <= 1'b0;
      acc_r       <= '0;
      y_r         <= '0;
      prob_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      s1_v_r     <= (state_r == S_ISSUE);
      s2_v_r     <= s1_v_r;
      div_sent_r <= (state_r == S_OSET);
      if (s2_v_r) acc_r <= acc_r + 40'(prod_r);
      if (emit_go)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (do_pop && q_data.kind == CMD_FEAT) begin
            feat_vld_r[q_data.index[5:0]] <= 1'b1;
            if ({1'b0, q_data.index[5:0]} + 7'd1 > feat_cnt_r)
              feat_cnt_r <= {1'b0, q_data.index[5:0]} + 7'd1;
          end
          if (do_pop && q_data.kind == CMD_RUN) begin
            cnt_r       <= (cfg.param_count > 13'(PARAM_DEPTH)) ? 13'(PARAM_DEPTH)
                                                                 : cfg.param_count;
            ptr_r       <= '0;
            n_in_r      <= clamp_n((cfg.input_width != 7'd0) ? cfg.input_width : feat_cnt_r);
            nh_r        <= nh_w;
            layer_r     <= '0;
            src_feat_r  <= 1'b1;
            dst_bank_r  <= 1'b0;
            out_layer_r <= 1'b0;
            neur_r      <= '0;
            n_out_r     <= clamp_n(hs[0]);
          end
        end
        S_NEUR: begin
          acc_r  <= '0;
          elem_r <= '0;
        end
        S_ISSUE: begin
          if (ptr_r < cnt_r) ptr_r <= ptr_r + 13'd1;
          if (!bias_elem) elem_r <= elem_r + 7'd1;
        end
        S_FIN: begin
          if (!out_layer_r) neur_r <= neur_r + 7'd1;
          else              y_r    <= fin_w;
        end
        S_SIG: prob_r <= sigmoid_q16(y_r);
        S_EMIT: if (emit_go) neur_r <= neur_r + 7'd1;
        S_LAYER: begin
          // swap banks: this layer's results feed the next one
          src_feat_r <= 1'b0;
          src_bank_r <= dst_bank_r;
          dst_bank_r <= !dst_bank_r;
          n_in_r     <= n_out_r;
          layer_r    <= layer_r + 3'd1;
          neur_r     <= '0;
          if (layer_r + 3'd1 < nh_r) n_out_r <= clamp_n(hs[layer_r[1:0] + 2'd1]);
        end
        S_OSET: begin
          out_layer_r <= 1'b1;
          neur_r      <= '0;
          if (cfg.output_width != 7'd0) n_out_r <= clamp_n(cfg.output_width);
          else if (div_done) begin
            if (div_r == 7'd0 && div_q != 13'd0)
              n_out_r <= (div_q > 13'(MAX_NEURONS)) ? 7'(MAX_NEURONS) : div_q[6:0];
            else
              n_out_r <= 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_idx_r  <= neur_r[5:0];
      out_val_r  <= y_r;
      out_prob_r <= prob_r;
      out_last_r <= (neur_r + 7'd1 == n_out_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign o_index    = out_idx_r;
  assign o_value    = out_val_r;
  assign o_prob     = out_prob_r;
  assign o_last     = out_last_r;

endmodule

>>> rtl/mlp_inference_relu_core.sv
// Top level of the MLP inference core: configuration registers, front end,
// command queue and compute engine. Depends on mlpir_pkg and the mlpir_* modules.
`timescale 1ns / 1ps
`include "mlp_inference_relu_core_macros.svh"

// Parameter and feature loads are taken one per cycle while the command queue
// has room and retired by the engine one per cycle while it is idle. A run
// streams weights from the parameter memory, one weight per cycle, through a
// three-stage multiply-accumulate pipeline: each neuron issues its weights and
// bias, then drains the pipeline and finishes, and the run adds a sigmoid step
// and, when output_width is zero, an output-count division. Results leave
// through a register, one output neuron per transfer, index 0 first; the engine
// moves on to the next neuron while a result waits. Configuration must be
// written only while no run is in progress; the block does not enforce this.
module mlp_inference_relu_core import mlpir_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [11:0] index, [27:12] value, [31:28] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] out_index, [21:6] out_value, [37:22] probability
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t       cfg_r;
  fifo_stat_t q_stat;
  cmd_t       push_data, pop_data;
  logic       push, pop;
  logic [5:0]  o_index;
  logic [15:0] o_value, o_prob;
  logic        out_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INPUT_WIDTH:   cfg_r.input_width   <= cfg_data[6:0];
        REG_HIDDEN_LAYERS: cfg_r.hidden_layers <= cfg_data[2:0];
        REG_HIDDEN_A:      cfg_r.hidden_a      <= cfg_data[6:0];
        REG_HIDDEN_B:      cfg_r.hidden_b      <= cfg_data[6:0];
        REG_HIDDEN_C:      cfg_r.hidden_c      <= cfg_data[6:0];
        REG_HIDDEN_D:      cfg_r.hidden_d      <= cfg_data[6:0];
        REG_OUTPUT_WIDTH:  cfg_r.output_width  <= cfg_data[6:0];
        REG_PARAM_COUNT:   cfg_r.param_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  mlpir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (push),
    .q_data    (push_data)
  );

  mlpir_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  mlpir_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .o_index    (o_index),
    .o_value    (o_value),
    .o_prob     (o_prob),
    .o_last     (out_tlast)
  );

  assign out_tdata = {2'b00, o_prob, o_value, o_index};
  assign out_fire  = out_tvalid && out_tready;

  `MLPIR_ASSERT_NEXT(a_prob_same_in_run, out_fire && !out_tlast, !out_tvalid || out_tdata[37:22] == $past(out_tdata[37:22]), "probability changed within a run")
  `MLPIR_ASSERT_NEXT(a_index_step, out_fire && !out_tlast, !out_tvalid || out_tdata[5:0] == 6'($past(out_tdata[5:0]) + 6'd1), "output index did not advance by one")
  `MLPIR_ASSERT_NEXT(a_new_run_index, out_fire && out_tlast, !out_tvalid || out_tdata[5:0] == 6'd0, "run did not start at output zero")
  `MLPIR_ASSERT(a_queue_sane, !(q_stat.full && q_stat.empty), "command queue full and empty at once")

endmodule

>>> tb/tb_mlp_inference_relu_core.sv
// Self-checking bench for mlp_inference_relu_core: load, feature and run streams
// checked against an in-bench Q8.8 forward-pass predictor. Depends on mlpir_pkg and the core.
`timescale 1ns / 1ps

module tb_mlp_inference_relu_core;
  import mlpir_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] index;
    logic [15:0] value;
  } cmd_item_t;

  typedef struct {
    logic [5:0]  index;
    logic [15:0] value;
    logic [15:0] prob;
    logic        last;
  } neuron_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  mlp_inference_relu_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cmd_item_t   pending_cmds[$];
  neuron_out_t expected_outs[$];

  // shadow of the block state
  logic [15:0]        pmem [PARAM_DEPTH];
  bit                 pmem_written [PARAM_DEPTH];
  logic signed [15:0] feat [MAX_NEURONS];
  int                 feat_count;
  int                 w_input, w_hidden_layers, w_output, w_params;
  int                 w_size [4];

  int  n_items, n_runs, n_results, n_mismatch;
  int  cycle_cnt = 0;
  int  burst_left, gap_left;
  int  hold_left;
  bit  hold_done;

  function automatic int clip(int v, int hi);
    return v > hi ? hi : v;
  endfunction

  function automatic logic signed [15:0] next_param(ref int ptr, input int count);
    logic signed [15:0] p;
    p = '0;
    if (ptr < count) begin
      p = pmem[ptr];
      ptr++;
    end
    return p;
  endfunction

  function automatic logic [15:0] sigmoid_of(logic signed [15:0] y);
    int a, seg, frac, p;
    a = (y < 0) ? -int'(y) : int'(y);
    if (a >= 2048) p = SIG_TAB[16];
    else begin
      seg  = a >> 7;
      frac = a & 127;
      p = SIG_TAB[seg] + (((SIG_TAB[seg + 1] - SIG_TAB[seg]) * frac) >> 7);
    end
    return (y < 0) ? 16'(65536 - p) : 16'(p);
  endfunction

  function automatic void compute_layer(ref logic signed [15:0] src [MAX_NEURONS],
                                        ref logic signed [15:0] dst [MAX_NEURONS],
                                        input int n_in, input int n_out, input bit relu,
                                        ref int ptr, input int count);
    logic [39:0]        acc;
    logic signed [15:0] w;
    logic signed [31:0] prod;
    logic signed [31:0] q;
    for (int j = 0; j < n_out; j++) begin
      acc = '0;
      for (int i = 0; i < n_in; i++) begin
        w    = next_param(ptr, count);
        prod = w * src[i];
        acc  = acc + {{8{prod[31]}}, prod};
      end
      w   = next_param(ptr, count);
      acc = acc + {{16{w[15]}}, w, 8'h00};
      q   = $signed(acc[39:8]);
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      if (relu && q < 0) q = 0;
      dst[j] = q[15:0];
    end
  endfunction

  function automatic void push_cmd(logic [1:0] mode, logic [11:0] index, logic [15:0] value);
    cmd_item_t c;
    c.mode = mode; c.index = index; c.value = value;
    pending_cmds.push_back(c);
    n_items++;
    if (mode == MODE_PARAM) begin
      pmem[index] = value;
      pmem_written[index] = 1'b1;
    end else if (mode == MODE_FEAT && index < MAX_NEURONS) begin
      feat[index] = value;
      if (index + 1 > feat_count) feat_count = index + 1;
    end
  endfunction

  // Fill any parameter word the pass will read, then predict its outputs.
  function automatic void push_run();
    int count, ptr, n_in, nh, n_out, o, rem, reach;
    logic signed [15:0] a_buf [MAX_NEURONS];
    logic signed [15:0] b_buf [MAX_NEURONS];
    logic [15:0] prob;
    neuron_out_t r;
    count = clip(w_params, PARAM_DEPTH);
    nh    = clip(w_hidden_layers, MAX_HIDDEN);
    n_in  = clip(w_input != 0 ? w_input : feat_count, MAX_NEURONS);
    reach = 0;
    for (int li = 0; li < nh; li++) begin
      n_out = clip(w_size[li], MAX_NEURONS);
      reach = clip(reach + n_out * (n_in + 1), count);
      n_in  = n_out;
    end
    o   = w_output != 0 ? clip(w_output, MAX_NEURONS) : 1;
    rem = count - reach;
    if (w_output == 0 && rem >= n_in + 1 && rem % (n_in + 1) == 0)
      o = clip(rem / (n_in + 1), MAX_NEURONS);
    reach = clip(reach + o * (n_in + 1), count);
    for (int k = 0; k < reach; k++)
      if (!pmem_written[k]) push_cmd(MODE_PARAM, 12'(k), 16'($urandom));

    push_cmd(MODE_RUN, 12'($urandom), 16'($urandom));
    n_runs++;
    ptr  = 0;
    n_in = clip(w_input != 0 ? w_input : feat_count, MAX_NEURONS);
    a_buf = feat;
    for (int li = 0; li < nh; li++) begin
      n_out = clip(w_size[li], MAX_NEURONS);
      compute_layer(a_buf, b_buf, n_in, n_out, 1'b1, ptr, count);
      a_buf = b_buf;
      n_in  = n_out;
    end
    compute_layer(a_buf, b_buf, n_in, o, 1'b0, ptr, count);
    prob = sigmoid_of(b_buf[0]);
    for (int j = 0; j < o; j++) begin
      r.index = 6'(j); r.value = b_buf[j]; r.prob = prob; r.last = (j == o - 1);
      expected_outs.push_back(r);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 13'(data);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INPUT_WIDTH:   w_input = data & 'h7f;
      REG_HIDDEN_LAYERS: w_hidden_layers = data & 'h7;
      REG_HIDDEN_A:      w_size[0] = data & 'h7f;
      REG_HIDDEN_B:      w_size[1] = data & 'h7f;
      REG_HIDDEN_C:      w_size[2] = data & 'h7f;
      REG_HIDDEN_D:      w_size[3] = data & 'h7f;
      REG_OUTPUT_WIDTH:  w_output = data & 'h7f;
      default:           w_params = data & 'h1fff;
    endcase
  endtask

  task automatic write_all(int iw, int hl, int a, int b, int c, int d, int ow, int pc);
    write_reg(REG_INPUT_WIDTH, iw);
    write_reg(REG_HIDDEN_LAYERS, hl);
    write_reg(REG_HIDDEN_A, a);
    write_reg(REG_HIDDEN_B, b);
    write_reg(REG_HIDDEN_C, c);
    write_reg(REG_HIDDEN_D, d);
    write_reg(REG_OUTPUT_WIDTH, ow);
    write_reg(REG_PARAM_COUNT, pc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_outs.size() != 0)
      @(posedge clk);
    // trailing loads may still sit in the command queue
    repeat (80) @(posedge clk);
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64;
    if (r == 1) return 100;
    return $urandom_range(0, 6);
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    cmd_item_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, c.value, c.index};
        in_tuser  <= c.mode;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, while results are queued up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && expected_outs.size() >= 8 && in_tvalid) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) out_tready <= 1'b0;
    else case ((cycle_cnt / 700) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    neuron_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_outs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        e = expected_outs.pop_front();
        if (out_tdata[5:0] !== e.index || out_tdata[21:6] !== e.value ||
            out_tdata[37:22] !== e.prob || out_tlast !== e.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp idx %0d val %h prob %h last %b, got idx %0d val %h prob %h last %b",
                     e.index, e.value, e.prob, e.last, out_tdata[5:0], out_tdata[21:6],
                     out_tdata[37:22], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_mlp_inference_relu_core NOT OK");
      $finish;
    end
  end

  initial begin
    int iw, hl, ow, pc, nsz, kind, n_in_hint;
    int sz [4];
    bit big;
    for (int k = 0; k < PARAM_DEPTH; k++) begin
      pmem[k] = '0;
      pmem_written[k] = 1'b0;
    end
    for (int k = 0; k < MAX_NEURONS; k++) feat[k] = '0;
    feat_count = 0;
    w_input = 0; w_hidden_layers = 0; w_output = 0; w_params = 0;
    for (int k = 0; k < 4; k++) w_size[k] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty network, ignored items, feature extremes
    push_run();
    push_cmd(MODE_NONE, 12'hfff, 16'hffff);
    push_cmd(MODE_FEAT, 12'hfff, 16'h1234);
    push_cmd(MODE_FEAT, 12'd63, 16'h8000);
    push_cmd(MODE_FEAT, 12'd0, 16'h7fff);
    push_run();
    wait_drained();

    // directed: saturation both ways, ReLU, inferred output count
    write_all(2, 1, 2, 0, 0, 0, 0, 12);
    push_cmd(MODE_FEAT, 12'd1, 16'h7fff);
    push_cmd(MODE_PARAM, 12'd0, 16'h7fff);
    push_cmd(MODE_PARAM, 12'd1, 16'h7fff);
    push_cmd(MODE_PARAM, 12'd2, 16'h7fff);
    push_cmd(MODE_PARAM, 12'd3, 16'h8000);
    push_cmd(MODE_PARAM, 12'd4, 16'h8000);
    push_cmd(MODE_PARAM, 12'd5, 16'h8000);
    push_cmd(MODE_PARAM, 12'd6, 16'h0100);
    push_cmd(MODE_PARAM, 12'd7, 16'hff00);
    push_cmd(MODE_PARAM, 12'd8, 16'h8000);
    push_run();
    push_cmd(MODE_PARAM, 12'hfff, 16'h5a5a);
    push_run();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      iw = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 64 :
           $urandom_range(1, 6));
      if (ph == 3) iw = 127;
      hl = $urandom_range(0, 4);
      if (ph == 5) hl = 7;
      for (int k = 0; k < 4; k++) sz[k] = pick_size();
      if (ph == 4) for (int k = 0; k < 4; k++) sz[k] = 64;
      ow = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (ph == 2) ow = 64;
      if (ph == 6) ow = 127;
      big = (iw == 0 || iw > 6);
      for (int k = 0; k < 4; k++) if (sz[k] > 6) big = 1;
      if (big) pc = $urandom_range(0, 160);
      else begin
        kind = $urandom_range(0, 3);
        pc = (kind == 0) ? 4096 : (kind == 1) ? 8191 : $urandom_range(0, 400);
        if (kind == 2 && ow == 0) begin
          // land the leftover on a whole number of output neurons
          nsz = 0;
          n_in_hint = iw;
          for (int k = 0; k < clip(hl, MAX_HIDDEN); k++) begin
            nsz += clip(sz[k], 64) * (n_in_hint + 1);
            n_in_hint = clip(sz[k], 64);
          end
          pc = nsz + $urandom_range(1, 5) * (n_in_hint + 1);
        end
      end
      write_all(iw, hl, sz[0], sz[1], sz[2], sz[3], ow, pc);
      for (int s = 0; s < 5; s++) begin
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(0, 4))
            push_cmd(MODE_FEAT, 12'($urandom_range(0, 63)), 16'($urandom));
          repeat ($urandom_range(0, 4))
            push_cmd(MODE_PARAM, 12'($urandom_range(0, clip(pc, 4095))), 16'($urandom));
          push_run();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0:       push_cmd(MODE_PARAM, 12'($urandom), 16'($urandom));
              1:       push_cmd(MODE_FEAT, 12'($urandom), 16'($urandom));
              default: push_cmd(MODE_NONE, 12'($urandom), 16'($urandom));
            endcase
          end
        end
      end
      wait_drained();
    end

    $display("covered %0d input transfers, %0d forward passes, %0d result transfers",
             n_items, n_runs, n_results);
    $display("config sweeps included clamped widths, four hidden layers and inferred outputs");
    if (n_mismatch == 0) begin
      $display("tb_mlp_inference_relu_core OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb_mlp_inference_relu_core NOT OK");
    end
    $finish;
  end

endmodule
